// ----- rtl/core/sird_pkg.sv -----
// Shared types, constants and the control program of the signed radix printer.
`timescale 1ns / 1ps
`default_nettype none

package sird_pkg;

   // Widths of the value path and of the configuration registers.
   localparam int VAL_W     = 32;
   localparam int CNT_W     = $clog2(VAL_W);
   localparam int NDIG      = VAL_W;
   localparam int LEN_W     = CNT_W + 1;
   localparam int BASE_W    = 5;
   localparam int WIDE_W    = BASE_W + 1;
   localparam int SYM_W     = 8;
   localparam int TBL_W     = 64;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Sign symbols that may not appear in the digit table, and the empty symbol.
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_NONE  = 8'h00;

   // Steps of the control program.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE,
      ST_SYMCHK,
      ST_SHIFT,
      ST_SIGN,
      ST_DIGIT,
      ST_BAD
   } step_type;

   // Branch conditions a control word can test.
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_START,
      C_IDX_MORE,
      C_CNT_MORE,
      C_PTR_MORE
   } cond_type;

   // Checks that divert the program to the bad-base step.
   typedef enum logic [1:0] {
      F_NONE,
      F_RANGE,
      F_SYM
   } fail_type;

   // One control word of the program.
   typedef struct packed {
      cond_type cond;
      step_type step_true;
      step_type step_false;
      fail_type fail;
      logic     load;
      logic     idx_clr;
      logic     idx_inc;
      logic     shift;
      logic     ptr_init;
      logic     emit_sign;
      logic     emit_digit;
      logic     emit_bad;
   } ctrl_word_type;

   // Status from the base checker.
   typedef struct packed {
      logic range_bad;
      logic sym_bad;
      logic idx_more;
   } chk_stat_type;

   // Status from the digit accumulator.
   typedef struct packed {
      logic neg;
      logic cnt_more;
      logic ptr_more;
      logic ptr_last;
   } acc_stat_type;

   // Everything the sequencer branches on.
   typedef struct packed {
      logic         start;
      chk_stat_type chk;
      acc_stat_type acc;
   } status_type;

   // Symbol byte for digit d out of the two table registers.
   function automatic logic [SYM_W-1:0] sym_of(input logic [TBL_W-1:0] lo,
                                               input logic [TBL_W-1:0] hi,
                                               input logic [3:0]       d);
      logic [TBL_W-1:0] row;
      row = d[3] ? hi : lo;
      return row[{d[2:0], 3'b000} +: SYM_W];
   endfunction

   // Control store: one word per step.
   function automatic ctrl_word_type ucode_rom(input step_type s);
      ctrl_word_type w;
      w = '0;
      case (s)
         ST_IDLE: begin
            w.cond       = C_START;
            w.step_true  = ST_RANGE;
            w.step_false = ST_IDLE;
            w.load       = 1'b1;
         end
         ST_RANGE: begin
            w.cond       = C_ALWAYS;
            w.step_true  = ST_SYMCHK;
            w.step_false = ST_SYMCHK;
            w.fail       = F_RANGE;
            w.idx_clr    = 1'b1;
         end
         ST_SYMCHK: begin
            w.cond       = C_IDX_MORE;
            w.step_true  = ST_SYMCHK;
            w.step_false = ST_SHIFT;
            w.fail       = F_SYM;
            w.idx_inc    = 1'b1;
         end
         ST_SHIFT: begin
            w.cond       = C_CNT_MORE;
            w.step_true  = ST_SHIFT;
            w.step_false = ST_SIGN;
            w.shift      = 1'b1;
         end
         ST_SIGN: begin
            w.cond       = C_ALWAYS;
            w.step_true  = ST_DIGIT;
            w.step_false = ST_DIGIT;
            w.ptr_init   = 1'b1;
            w.emit_sign  = 1'b1;
         end
         ST_DIGIT: begin
            w.cond       = C_PTR_MORE;
            w.step_true  = ST_DIGIT;
            w.step_false = ST_IDLE;
            w.emit_digit = 1'b1;
         end
         ST_BAD: begin
            w.cond       = C_ALWAYS;
            w.step_true  = ST_IDLE;
            w.step_false = ST_IDLE;
            w.emit_bad   = 1'b1;
         end
         default: begin
            w.cond       = C_ALWAYS;
            w.step_true  = ST_IDLE;
            w.step_false = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/signed_int_to_radix_digits.sv -----
// Top level of the signed radix printer: registers, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none

// A signed 32-bit value is taken when start is high and busy is low, and its
// text in the configured base comes out one symbol per rsp_valid strobe: a
// minus sign first for negative values, then the digits, most significant
// first, with rsp_last on the final one. The strobes of one value follow one
// another in back-to-back cycles and cannot be held off by the receiver. For
// a valid base, the last symbol is on the ports in the first cycle with busy
// low again; before the digits, the symbol table check reads one table entry
// per cycle and the digit accumulator takes in one magnitude bit per cycle.
// A bad base gives its single flagged result. The user must write
// configuration only while busy is low; the block itself does not enforce it.
module signed_int_to_radix_digits
   import sird_pkg::*;
#(
   parameter int MAX_BASE = 16
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [VAL_W-1:0]  req_value,
   output logic                          rsp_valid,
   output logic [SYM_W-1:0]              rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_bad_base,
   input  wire logic                     csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [TBL_W-1:0]         csr_data
);

   localparam int DIG_W = $clog2(MAX_BASE);

   logic [BASE_W-1:0] radix_ff;
   logic [TBL_W-1:0]  symbols_low_ff;
   logic [TBL_W-1:0]  symbols_high_ff;

   ctrl_word_type     ctrl;
   status_type        status;
   chk_stat_type      chk_stat;
   acc_stat_type      acc_stat;
   logic [DIG_W-1:0]  cur_digit;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [SYM_W-1:0]  rsp_symbol_ff;
   logic [SYM_W-1:0]  rsp_symbol_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;
   logic              rsp_bad_base_ff;
   logic              rsp_bad_base_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RADIX:        radix_ff        <= csr_data[BASE_W-1:0];
            CSR_SYMBOLS_LOW:  symbols_low_ff  <= csr_data;
            CSR_SYMBOLS_HIGH: symbols_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer status.
   always_comb begin
      status.start = start;
      status.chk   = chk_stat;
      status.acc   = acc_stat;
   end

   sird_ucode_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   sird_base_chk #(
      .MAX_BASE (MAX_BASE)
   ) u_chk (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .radix        (radix_ff),
      .symbols_low  (symbols_low_ff),
      .symbols_high (symbols_high_ff),
      .stat         (chk_stat)
   );

   sird_digit_acc #(
      .MAX_BASE (MAX_BASE)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .start     (start),
      .value     (req_value),
      .radix     (radix_ff),
      .stat      (acc_stat),
      .cur_digit (cur_digit)
   );

   // Result selection for the current step.
   always_comb begin
      rsp_valid_in    = (ctrl.emit_sign & acc_stat.neg) | ctrl.emit_digit | ctrl.emit_bad;
      rsp_last_in     = ctrl.emit_bad | (ctrl.emit_digit & acc_stat.ptr_last);
      rsp_bad_base_in = ctrl.emit_bad;
      if (ctrl.emit_bad) begin
         rsp_symbol_in = SYM_NONE;
      end else if (ctrl.emit_digit) begin
         rsp_symbol_in = sym_of(symbols_low_ff, symbols_high_ff, 4'(cur_digit));
      end else begin
         rsp_symbol_in = SYM_MINUS;
      end
   end

   // Output register: each symbol is shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff   <= rsp_symbol_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_bad_base_ff <= rsp_bad_base_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol   = rsp_symbol_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_bad_base = rsp_bad_base_ff;

endmodule

`default_nettype wire

// ----- rtl/core/sird_ucode_seq.sv -----
// Microcode sequencer: step register, control store lookup and branch logic.
`timescale 1ns / 1ps
`default_nettype none

module sird_ucode_seq
   import sird_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire status_type    status,
   output ctrl_word_type      ctrl,
   output logic               busy
);

   step_type step_ff;
   step_type step_in;
   logic     cond_hit;
   logic     fail_hit;

   // Control word and busy flag of the current step.
   always_comb begin
      ctrl = ucode_rom(step_ff);
      busy = (step_ff != ST_IDLE);
   end

   // Next step: a failed check wins, otherwise take the branch.
   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:   cond_hit = 1'b1;
         C_START:    cond_hit = status.start;
         C_IDX_MORE: cond_hit = status.chk.idx_more;
         C_CNT_MORE: cond_hit = status.acc.cnt_more;
         C_PTR_MORE: cond_hit = status.acc.ptr_more;
         default:    cond_hit = 1'b1;
      endcase
      case (ctrl.fail)
         F_RANGE: fail_hit = status.chk.range_bad;
         F_SYM:   fail_hit = status.chk.sym_bad;
         default: fail_hit = 1'b0;
      endcase
      if (fail_hit) begin
         step_in = ST_BAD;
      end else if (cond_hit) begin
         step_in = ctrl.step_true;
      end else begin
         step_in = ctrl.step_false;
      end
   end

   // Step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sird_base_chk.sv -----
// Base checker: range test of the base and a walk over the symbol table.
`timescale 1ns / 1ps
`default_nettype none

module sird_base_chk
   import sird_pkg::*;
#(
   parameter int MAX_BASE = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctrl_word_type       ctrl,
   input  wire logic [BASE_W-1:0]   radix,
   input  wire logic [TBL_W-1:0]    symbols_low,
   input  wire logic [TBL_W-1:0]    symbols_high,
   output chk_stat_type             stat
);

   localparam int IDX_W = $clog2(MAX_BASE);

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [SYM_W-1:0] cur_sym;
   logic             dup_hit;

   // The base must lie between two and the largest supported base.
   // The symbol under test may not be a sign nor repeat a later symbol in use.
   always_comb begin
      stat.range_bad = (radix < BASE_W'(2)) || (radix > BASE_W'(MAX_BASE));
      cur_sym = sym_of(symbols_low, symbols_high, 4'(idx_ff));
      dup_hit = 1'b0;
      for (int k = 0; k < MAX_BASE; k++) begin
         if ((BASE_W'(k) > BASE_W'(idx_ff)) && (BASE_W'(k) < radix) &&
             (sym_of(symbols_low, symbols_high, 4'(k)) == cur_sym)) begin
            dup_hit = 1'b1;
         end
      end
      stat.sym_bad  = (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS) || dup_hit;
      stat.idx_more = (BASE_W'(idx_ff) + BASE_W'(1)) < radix;
   end

   // Table index.
   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_clr) begin
         idx_in = '0;
      end else if (ctrl.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sird_digit_acc.sv -----
// Digit accumulator: shifts the magnitude in bit by bit as base-N digits.
`timescale 1ns / 1ps
`default_nettype none

module sird_digit_acc
   import sird_pkg::*;
#(
   parameter int MAX_BASE = 16
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_word_type            ctrl,
   input  wire logic                     start,
   input  wire logic signed [VAL_W-1:0]  value,
   input  wire logic [BASE_W-1:0]        radix,
   output acc_stat_type                  stat,
   output logic [$clog2(MAX_BASE)-1:0]   cur_digit
);

   localparam int DIG_W = $clog2(MAX_BASE);

   logic [VAL_W-1:0] mag_ff;
   logic [VAL_W-1:0] mag_in;
   logic             neg_ff;
   logic             neg_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [CNT_W-1:0] ptr_ff;
   logic [CNT_W-1:0] ptr_in;
   logic [DIG_W-1:0] digits_ff [NDIG];
   logic [DIG_W-1:0] digits_in [NDIG];
   logic [NDIG:0]    gen;
   logic [NDIG:0]    prop;
   logic [NDIG:0]    alive;
   logic [NDIG:0]    csum;
   logic [NDIG:0]    carry;
   logic             load;

   assign load = ctrl.load & start;

   // Doubling a digit carries out when 2d >= base, or when 2d + 1 == base
   // and a carry comes in; the carries are resolved by one wide add.
   always_comb begin
      logic [WIDE_W-1:0] dbl;
      gen  = '0;
      prop = '0;
      for (int i = 0; i < NDIG; i++) begin
         dbl     = WIDE_W'({digits_ff[i], 1'b0});
         gen[i]  = dbl >= WIDE_W'(radix);
         prop[i] = (dbl | WIDE_W'(1)) == WIDE_W'(radix);
      end
      alive = gen | prop;
      csum  = alive + gen + (NDIG + 1)'(mag_ff[VAL_W-1]);
      carry = csum ^ alive ^ gen;
   end

   // Next digit vector: clear on load, double and add the next bit on shift.
   always_comb begin
      logic [WIDE_W-1:0] t;
      for (int i = 0; i < NDIG; i++) begin
         t = WIDE_W'({digits_ff[i], carry[i]});
         if (gen[i] | (prop[i] & carry[i])) begin
            t = t - WIDE_W'(radix);
         end
         if (load) begin
            digits_in[i] = '0;
         end else if (ctrl.shift) begin
            digits_in[i] = t[DIG_W-1:0];
         end else begin
            digits_in[i] = digits_ff[i];
         end
      end
   end

   // Magnitude, sign and counters.
   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      ptr_in = ptr_ff;
      if (load) begin
         neg_in = value[VAL_W-1];
         mag_in = value[VAL_W-1] ? (VAL_W'(0) - $unsigned(value)) : $unsigned(value);
         cnt_in = '0;
         len_in = LEN_W'(1);
      end else if (ctrl.shift) begin
         mag_in = {mag_ff[VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         len_in = len_ff + LEN_W'(carry[len_ff]);
      end
      if (ctrl.ptr_init) begin
         ptr_in = CNT_W'(len_ff - LEN_W'(1));
      end else if (ctrl.emit_digit) begin
         ptr_in = ptr_ff - CNT_W'(1);
      end
   end

   // Status to the sequencer and the digit being printed.
   always_comb begin
      stat.neg      = neg_ff;
      stat.cnt_more = (cnt_ff != CNT_W'(VAL_W - 1));
      stat.ptr_more = (ptr_ff != '0);
      stat.ptr_last = (ptr_ff == '0);
      cur_digit     = digits_ff[ptr_ff];
   end

   // Counters are control state; the value path needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         len_ff <= LEN_W'(1);
         ptr_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         len_ff <= len_in;
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      digits_ff <= digits_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/sird_checker.sv -----
// Port checker for the signed radix printer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sird_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_symbol,
   input wire logic       rsp_last,
   input wire logic       rsp_bad_base
);

   // An accepted transaction makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted transaction");

   // Results only come out while a transaction is being worked on.
   a_valid_in_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy || $past(busy)))
      else $error("result shown with no transaction in progress");

   // The symbols of one value come in consecutive cycles up to the last one.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside the symbols of one value");

   // A bad-base result is a single, final, empty symbol.
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_base) |-> (rsp_last && (rsp_symbol == 8'h00)))
      else $error("bad-base result malformed");

   // Nothing follows the last symbol in the next cycle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result right after the last symbol");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_symbol   (rsp_symbol),
   .rsp_last     (rsp_last),
   .rsp_bad_base (rsp_bad_base)
);

`default_nettype wire
